// ===== src/mdlx_pkg.sv =====
`timescale 1ns / 1ps
package mdlx_pkg;

   localparam int MAX_LINKS_DEF = 64;
   localparam int LINK_TEXT_DEF = 64;

   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_RBRACK = 8'h5D;

   typedef enum logic [1:0] {
      KIND_DOC_ID  = 2'd0,
      KIND_LINK_ID = 2'd1,
      KIND_DOC_END = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PHASE_ID    = 2'd0,
      PHASE_TITLE = 2'd1,
      PHASE_BODY  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      NMODE_SKIP   = 2'd0,
      NMODE_DIGITS = 2'd1,
      NMODE_DONE   = 2'd2
   } nmode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_LINK,
      ST_END
   } ctrl_state_type;

   typedef struct packed {
      logic     in_ready;
      logic     load_in;
      logic     apply;
      logic     scan_start;
      logic     scan_step;
      logic     link_close;
      logic     link_commit;
      logic     out_load;
      kind_type out_kind;
      logic     out_last;
      logic     doc_reset;
   } ctrl_cmd_type;

   typedef struct packed {
      logic in_valid;
      logic is_close;
      logic is_id_nl;
      logic eod;
      logic scan_done;
      logic found;
      logic out_free;
   } ctrl_stat_type;

endpackage

// ===== src/mdlx_if.sv =====
`timescale 1ns / 1ps
interface mdlx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       end_of_doc;

   modport source (output valid, output byte_in, output end_of_doc, input ready);
   modport sink   (input valid, input byte_in, input end_of_doc, output ready);
endinterface

interface mdlx_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic signed [31:0] id_value;
   logic [6:0]         link_count;
   logic               set_full;
   logic               link_too_long;
   logic               last_result;

   modport source (output valid, output kind, output id_value, output link_count,
                   output set_full, output link_too_long, output last_result,
                   input ready);
   modport sink   (input valid, input kind, input id_value, input link_count,
                   input set_full, input link_too_long, input last_result,
                   output ready);
endinterface

// ===== src/mdlx_ram.sv =====
`timescale 1ns / 1ps
module mdlx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mdlx_ctrl.sv =====
`timescale 1ns / 1ps
module mdlx_ctrl import mdlx_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_stat_type stat,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.out_kind = KIND_DOC_ID;
      case (state_ff)
         ST_IDLE: begin
            cmd.in_ready = 1'b1;
            if (stat.in_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.is_close) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end else if (stat.is_id_nl) begin
               if (stat.out_free) begin
                  cmd.apply    = 1'b1;
                  cmd.out_load = 1'b1;
                  cmd.out_kind = KIND_DOC_ID;
                  cmd.out_last = !stat.eod;
                  state_in     = stat.eod ? ST_END : ST_IDLE;
               end
            end else begin
               cmd.apply = 1'b1;
               state_in  = stat.eod ? ST_END : ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            if (stat.found) begin
               cmd.link_close = 1'b1;
               state_in       = stat.eod ? ST_END : ST_IDLE;
            end else if (stat.out_free) begin
               cmd.link_close  = 1'b1;
               cmd.link_commit = 1'b1;
               cmd.out_load    = 1'b1;
               cmd.out_kind    = KIND_LINK_ID;
               cmd.out_last    = !stat.eod;
               state_in        = stat.eod ? ST_END : ST_IDLE;
            end
         end
         ST_END: begin
            if (stat.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_kind  = KIND_DOC_END;
               cmd.out_last  = 1'b1;
               cmd.doc_reset = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/mdlx_dp.sv =====
`timescale 1ns / 1ps
module mdlx_dp import mdlx_pkg::*; #(
   parameter int MAX_LINKS     = MAX_LINKS_DEF,
   parameter int LINK_TEXT_MAX = LINK_TEXT_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output ctrl_stat_type stat,
   mdlx_req_if.sink      req,
   mdlx_rsp_if.source    rsp
);

   localparam int CW = $clog2(MAX_LINKS + 1);
   localparam int AW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
   localparam int LW = $clog2(LINK_TEXT_MAX);
   localparam logic [LW-1:0] CHAR_LAST = LW'(LINK_TEXT_MAX - 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_LINKS);

   logic [7:0]    byte_ff;
   logic          eod_ff;
   phase_type     phase_ff, phase_in;
   logic          in_link_ff, in_link_in;
   logic [31:0]   accum_ff, accum_in;
   logic          sign_ff, sign_in;
   nmode_type     nmode_ff, nmode_in;
   logic [LW-1:0] char_ff, char_in;
   logic [CW-1:0] count_ff, count_in;
   logic          link_cut_ff, link_cut_in;
   logic          doc_full_ff, doc_full_in;
   logic          doc_cut_ff, doc_cut_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          cmp_valid_ff, cmp_valid_in;
   logic          found_ff, found_in;
   logic          rsp_valid_ff, rsp_valid_in;

   kind_type      out_kind_ff;
   logic [31:0]   out_value_ff;
   logic [6:0]    out_count_ff;
   logic          out_full_ff;
   logic          out_cut_ff;
   logic          out_last_ff;

   logic [31:0]   feed_accum;
   logic          feed_sign;
   nmode_type     feed_mode;
   logic          is_digit;
   logic          is_space;
   logic [31:0]   link_value;
   logic          set_full;
   logic          rd_pending;
   logic [31:0]   rd_data;
   logic [CW-1:0] count_after;
   logic [CW+6:0] count_wide;

   // atoi step on the latched byte
   always_comb begin
      is_digit   = (byte_ff >= CHAR_ZERO) && (byte_ff <= CHAR_NINE);
      is_space   = (byte_ff == CHAR_SPACE) || ((byte_ff >= CHAR_TAB) && (byte_ff <= CHAR_CR));
      feed_accum = accum_ff;
      feed_sign  = sign_ff;
      feed_mode  = nmode_ff;
      case (nmode_ff)
         NMODE_SKIP: begin
            if (!is_space) begin
               if (byte_ff == CHAR_PLUS) begin
                  feed_mode = NMODE_DIGITS;
               end else if (byte_ff == CHAR_MINUS) begin
                  feed_sign = 1'b1;
                  feed_mode = NMODE_DIGITS;
               end else if (is_digit) begin
                  feed_accum = 32'(byte_ff[3:0]);
                  feed_mode  = NMODE_DIGITS;
               end else begin
                  feed_mode = NMODE_DONE;
               end
            end
         end
         NMODE_DIGITS: begin
            if (is_digit) begin
               feed_accum = (accum_ff << 3) + (accum_ff << 1) + 32'(byte_ff[3:0]);
            end else begin
               feed_mode = NMODE_DONE;
            end
         end
         default: begin
         end
      endcase
   end

   assign link_value  = sign_ff ? (32'd0 - accum_ff) : accum_ff;
   assign set_full    = (count_ff >= COUNT_MAX);
   assign count_after = set_full ? count_ff : count_ff + 1'b1;
   assign rd_pending  = (rd_idx_ff < count_ff);

   always_comb begin
      phase_in    = phase_ff;
      in_link_in  = in_link_ff;
      accum_in    = accum_ff;
      sign_in     = sign_ff;
      nmode_in    = nmode_ff;
      char_in     = char_ff;
      count_in    = count_ff;
      link_cut_in = link_cut_ff;
      doc_full_in = doc_full_ff;
      doc_cut_in  = doc_cut_ff;
      if (cmd.doc_reset) begin
         phase_in    = PHASE_ID;
         in_link_in  = 1'b0;
         accum_in    = '0;
         sign_in     = 1'b0;
         nmode_in    = NMODE_SKIP;
         char_in     = '0;
         count_in    = '0;
         link_cut_in = 1'b0;
         doc_full_in = 1'b0;
         doc_cut_in  = 1'b0;
      end else if (cmd.apply) begin
         case (phase_ff)
            PHASE_ID: begin
               if (byte_ff == CHAR_LF) begin
                  phase_in = PHASE_TITLE;
                  accum_in = '0;
                  sign_in  = 1'b0;
                  nmode_in = NMODE_SKIP;
               end else begin
                  accum_in = feed_accum;
                  sign_in  = feed_sign;
                  nmode_in = feed_mode;
               end
            end
            PHASE_TITLE: begin
               if (byte_ff == CHAR_LF) begin
                  phase_in = PHASE_BODY;
               end
            end
            default: begin
               if (in_link_ff) begin
                  if (byte_ff != CHAR_LPAREN) begin
                     if (char_ff < CHAR_LAST) begin
                        char_in  = char_ff + 1'b1;
                        accum_in = feed_accum;
                        sign_in  = feed_sign;
                        nmode_in = feed_mode;
                     end else begin
                        link_cut_in = 1'b1;
                        doc_cut_in  = 1'b1;
                     end
                  end
               end else if (byte_ff == CHAR_RBRACK) begin
                  in_link_in  = 1'b1;
                  accum_in    = '0;
                  sign_in     = 1'b0;
                  nmode_in    = NMODE_SKIP;
                  char_in     = '0;
                  link_cut_in = 1'b0;
               end
            end
         endcase
      end else begin
         if (cmd.link_close) begin
            in_link_in = 1'b0;
         end
         if (cmd.link_commit) begin
            count_in = count_after;
            if (set_full) begin
               doc_full_in = 1'b1;
            end
         end
      end
   end

   // duplicate search: one read issued per cycle, compared in the following cycle
   always_comb begin
      rd_idx_in    = rd_idx_ff;
      cmp_valid_in = cmp_valid_ff;
      found_in     = found_ff;
      if (cmd.scan_start) begin
         rd_idx_in    = '0;
         cmp_valid_in = 1'b0;
         found_in     = 1'b0;
      end else if (cmd.scan_step) begin
         cmp_valid_in = rd_pending;
         if (rd_pending) begin
            rd_idx_in = rd_idx_ff + 1'b1;
         end
         if (cmp_valid_ff && (rd_data == link_value)) begin
            found_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_ID;
         in_link_ff   <= 1'b0;
         accum_ff     <= '0;
         sign_ff      <= 1'b0;
         nmode_ff     <= NMODE_SKIP;
         char_ff      <= '0;
         count_ff     <= '0;
         link_cut_ff  <= 1'b0;
         doc_full_ff  <= 1'b0;
         doc_cut_ff   <= 1'b0;
         rd_idx_ff    <= '0;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         in_link_ff   <= in_link_in;
         accum_ff     <= accum_in;
         sign_ff      <= sign_in;
         nmode_ff     <= nmode_in;
         char_ff      <= char_in;
         count_ff     <= count_in;
         link_cut_ff  <= link_cut_in;
         doc_full_ff  <= doc_full_in;
         doc_cut_ff   <= doc_cut_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_valid_ff <= cmp_valid_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // reported link count keeps the low 7 bits of the count (modulo 128)
   always_comb begin
      case (cmd.out_kind)
         KIND_LINK_ID: count_wide = {7'd0, count_after};
         default:      count_wide = {7'd0, count_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         byte_ff <= req.byte_in;
         eod_ff  <= req.end_of_doc;
      end
      if (cmd.out_load) begin
         out_kind_ff  <= cmd.out_kind;
         out_last_ff  <= cmd.out_last;
         out_count_ff <= count_wide[6:0];
         case (cmd.out_kind)
            KIND_LINK_ID: begin
               out_value_ff <= link_value;
               out_full_ff  <= set_full;
               out_cut_ff   <= link_cut_ff;
            end
            KIND_DOC_END: begin
               out_value_ff <= '0;
               out_full_ff  <= doc_full_ff;
               out_cut_ff   <= doc_cut_ff;
            end
            default: begin
               out_value_ff <= link_value;
               out_full_ff  <= 1'b0;
               out_cut_ff   <= 1'b0;
            end
         endcase
      end
   end

   mdlx_ram #(
      .WIDTH (32),
      .DEPTH (MAX_LINKS)
   ) u_seen_ram (
      .clock   (clock),
      .wr_en   (cmd.link_commit && !set_full),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (link_value),
      .rd_en   (cmd.scan_step && rd_pending),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign req.ready = cmd.in_ready;

   assign stat.in_valid  = req.valid;
   assign stat.is_close  = (phase_ff == PHASE_BODY) && in_link_ff && (byte_ff == CHAR_RPAREN);
   assign stat.is_id_nl  = (phase_ff == PHASE_ID) && (byte_ff == CHAR_LF);
   assign stat.eod       = eod_ff;
   assign stat.scan_done = !rd_pending && !cmp_valid_ff;
   assign stat.found     = found_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp.ready;

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.kind          = out_kind_ff;
   assign rsp.id_value      = out_value_ff;
   assign rsp.link_count    = out_count_ff;
   assign rsp.set_full      = out_full_ff;
   assign rsp.link_too_long = out_cut_ff;
   assign rsp.last_result   = out_last_ff;

endmodule

// ===== src/markdown_link_id_extractor.sv =====
`timescale 1ns / 1ps
// Markdown link id extractor.
// req_ch carries one document byte per word with end_of_doc on the last byte.
// rsp_ch carries result words: document id when the first line's newline
// arrives, each new distinct link id when a link closes, and one end word
// after the last byte of a document. last_result marks the final word a byte
// produced.
// Timing: a byte is taken, decoded in the next cycle, and the next byte is
// taken only after decoding returns to idle, so no new byte is accepted
// while one is in work. A closing ')' in a link scans the stored link ids
// through the id RAM, one read per cycle. end_of_doc adds an end state for
// the end word. Results leave through a single output register.
// Reset clears all control state; the id set needs no clearing pass since
// only entries written in the current document are read.
// If rsp_ch stalls, a byte producing a result waits until the output
// register is free, and req_ch stays not ready until it is.
module markdown_link_id_extractor import mdlx_pkg::*; #(
   parameter int MAX_LINKS     = MAX_LINKS_DEF,
   parameter int LINK_TEXT_MAX = LINK_TEXT_DEF
) (
   input logic        clock,
   input logic        reset,
   mdlx_req_if.sink   req_ch,
   mdlx_rsp_if.source rsp_ch
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   mdlx_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   mdlx_dp #(
      .MAX_LINKS     (MAX_LINKS),
      .LINK_TEXT_MAX (LINK_TEXT_MAX)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.out_free)
      else $error("result register overwritten");

   a_one_word_at_a_time: assert property (@(posedge clock) disable iff (reset)
      cmd.load_in |=> !cmd.in_ready)
      else $error("input taken while a word is in work");

   a_no_duplicate_add: assert property (@(posedge clock) disable iff (reset)
      cmd.link_commit |-> !stat.found)
      else $error("duplicate link id added");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.kind == KIND_DOC_END)) |-> rsp_ch.last_result)
      else $error("end word not marked last");

endmodule
